[rtl/acu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acu_pkg: shared types and constants of the covariance update unit
// Command and status bundles between controller and datapath, state codes,
// operand selects and register reset values.
// ----------------------------------------------------------------------------
package acu_pkg;

	// default chain dimension and field widths
	localparam int DIMENSIONS_DEF = 4;
	localparam int IDX_W = 3;
	localparam int APB_AW = 3;
	localparam int DVD_W = 64;
	localparam int DVS_W = 33;

	// register reset values
	localparam logic [31:0] SCALE_RESET = 32'd92806;
	localparam logic [15:0] JITTER_RESET = 16'd1;

	// register index as taken from paddr[2]
	localparam logic REG_SCALE = 1'b0;
	localparam logic REG_JITTER = 1'b1;

	// multiplier operand selects
	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_SE,
		MUL_D,
		MUL_LO,
		MUL_HI
	} mul_op_t;

	// divider dividend selects
	typedef enum logic [1:0] {
		DIV_PROD,
		DIV_SUM,
		DIV_COV
	} div_src_t;

	// controller states
	typedef enum logic [4:0] {
		S_IDLE,
		S_EXTRA_MUL,
		S_EXTRA_DIV,
		S_EXTRA_WAIT,
		S_MEAN_DIV,
		S_MEAN_WAIT,
		S_LOAD_DI,
		S_PROD_MUL,
		S_T_DIV,
		S_T_WAIT,
		S_LO_MUL,
		S_HI_MUL,
		S_DEC_DIV,
		S_DEC_WAIT,
		S_ADD_SC,
		S_COMBINE,
		S_UPDATE
	} ctrl_state_t;

	typedef struct packed {
		mul_op_t          mul_op;
		logic             div_start;
		div_src_t         div_src;
		logic             div_plus1;
		logic             extra_load;
		logic             d_we;
		logic             di_load;
		logic             scaled_load;
		logic             acc_sub_load;
		logic             acc_add_load;
		logic             out_load;
		logic             update;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic sample_end;
		logic count_zero;
		logic out_free;
	} status_t;

endpackage

[rtl/acu_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acu_ram: generic single-port-write, registered-read memory
// One write and one read address per cycle, read data registered.
// ----------------------------------------------------------------------------
module acu_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/acu_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acu_div: iterative unsigned divider with round to nearest
// One quotient bit per cycle, then a rounding step (ties round up).
// ----------------------------------------------------------------------------
module acu_div
	import acu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic [DVD_W-1:0] quotient,
	output logic             done
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             run_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DVS_W-1:0] den_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W:0]   rem_sh;
	logic             fit;
	logic             round_up;

	// one restoring step
	assign rem_sh   = {rem_q, quo_q[DVD_W-1]};
	assign fit      = rem_sh >= {1'b0, den_q};
	assign round_up = {rem_q, 1'b0} >= {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DVD_W);
			end else if (run_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end else begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (run_q) begin
			if (cnt_q != '0) begin
				rem_q <= fit ? DVS_W'(rem_sh - {1'b0, den_q}) : rem_sh[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], fit};
			end else if (round_up) begin
				quo_q <= quo_q + 1'b1;
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

[rtl/acu_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acu_datapath: sample store, running sums, multiplier, divider, covariance
// Holds the running sums and count, forms means and deviations, updates
// one covariance entry at a time and keeps the output register.
// ----------------------------------------------------------------------------
module acu_datapath
	import acu_pkg::*;
#(
	parameter int DIM = DIMENSIONS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output status_t          status,
	input  logic [31:0]      scale,
	input  logic [15:0]      jitter,
	input  logic             in_fire,
	input  logic [31:0]      in_value,
	input  logic             in_last,
	input  logic             m_tready,
	output logic             out_valid,
	output logic [IDX_W-1:0] out_row,
	output logic [IDX_W-1:0] out_col,
	output logic [63:0]      out_cov,
	output logic             out_last
);

	localparam int PW = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int CDEPTH = DIM * DIM;
	localparam int CAW = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
	localparam logic [PW-1:0] POS_LAST = PW'(DIM - 1);
	localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] HI_CAP = 64'h0000_8000_0000_0000;

	function automatic logic [63:0] mag64(input logic [63:0] v);
		mag64 = v[63] ? (~v + 64'd1) : v;
	endfunction

	function automatic logic [63:0] from_mag(input logic neg, input logic [63:0] mag);
		if (neg) begin
			from_mag = mag[63] ? MIN64 : (~mag + 64'd1);
		end else begin
			from_mag = mag[63] ? MAX64 : mag;
		end
	endfunction

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			sat_add = s[64] ? MIN64 : MAX64;
		end else begin
			sat_add = s[63:0];
		end
	endfunction

	function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63]) begin
			sat_sub = s[64] ? MIN64 : MAX64;
		end else begin
			sat_sub = s[63:0];
		end
	endfunction

	logic [31:0]      cur_q [DIM];
	logic [63:0]      sum_q [DIM];
	logic [PW-1:0]    pos_q;
	logic [31:0]      count_q;
	logic [31:0]      dmag_q [DIM];
	logic             dneg_q [DIM];
	logic [31:0]      di_mag_q;
	logic             di_neg_q;
	logic             neg_q;
	logic [63:0]      prod_q;
	logic [63:0]      lo_q;
	logic [63:0]      extra_q;
	logic [63:0]      scaled_q;
	logic [63:0]      acc_q;
	logic             out_valid_q;
	logic [IDX_W-1:0] out_row_q;
	logic [IDX_W-1:0] out_col_q;
	logic [63:0]      out_cov_q;
	logic             out_last_q;

	logic [PW-1:0]    row_i;
	logic [PW-1:0]    col_i;
	logic [PW-1:0]    d_addr;
	logic             sample_end;
	logic [63:0]      div_quo;
	logic             div_done;
	logic [63:0]      div_dvd;
	logic [32:0]      div_dvs;
	logic [63:0]      cov_rd;
	logic [CAW-1:0]   cov_addr;
	logic [31:0]      mul_a;
	logic [31:0]      mul_b;
	logic [63:0]      mul_p;
	logic [63:0]      sum_sel;
	logic [63:0]      m_full;
	logic [31:0]      m32;
	logic [32:0]      d_full;
	logic [32:0]      d_neg;
	logic [64:0]      lo_r;
	logic [64:0]      r65;
	logic [63:0]      mq;
	logic [63:0]      new_cov;
	logic             diag;

	assign row_i  = cmd.row[PW-1:0];
	assign col_i  = cmd.col[PW-1:0];
	assign d_addr = cmd.di_load ? row_i : col_i;
	assign diag   = cmd.row == cmd.col;

	// item intake, sums and sample count
	assign sample_end = in_fire && (in_last || pos_q == POS_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			count_q <= '0;
			for (int k = 0; k < DIM; k++) begin
				cur_q[k] <= '0;
				sum_q[k] <= '0;
			end
		end else if (cmd.update) begin
			for (int k = 0; k < DIM; k++) begin
				sum_q[k] <= sat_add(sum_q[k], {{32{cur_q[k][31]}}, cur_q[k]});
				cur_q[k] <= '0;
			end
			if (count_q != '1) begin
				count_q <= count_q + 32'd1;
			end
		end else if (in_fire) begin
			cur_q[pos_q] <= in_value;
			pos_q        <= sample_end ? '0 : pos_q + 1'b1;
		end
	end

	// mean, clamp and deviation of one coordinate
	assign sum_sel = sum_q[row_i];
	assign m_full  = from_mag(sum_sel[63], div_quo);

	always_comb begin
		if (m_full[63] && (m_full[63:31] != '1)) begin
			m32 = 32'h8000_0000;
		end else if (!m_full[63] && (m_full[63:31] != '0)) begin
			m32 = 32'h7FFF_FFFF;
		end else begin
			m32 = m_full[31:0];
		end
	end

	assign d_full = {cur_q[row_i][31], cur_q[row_i]} - {m32[31], m32};
	assign d_neg  = ~d_full + 33'd1;

	always_ff @(posedge clk) begin
		if (cmd.d_we) begin
			dmag_q[row_i] <= d_full[32] ? d_neg[31:0] : d_full[31:0];
			dneg_q[row_i] <= d_full[32];
		end
		if (cmd.di_load) begin
			di_mag_q <= dmag_q[d_addr];
			di_neg_q <= dneg_q[d_addr];
		end
	end

	// shared 32 by 32 multiplier
	always_comb begin
		case (cmd.mul_op)
			MUL_SE: begin
				mul_a = scale;
				mul_b = {16'd0, jitter};
			end
			MUL_D: begin
				mul_a = di_mag_q;
				mul_b = dmag_q[d_addr];
			end
			MUL_LO: begin
				mul_a = div_quo[31:0];
				mul_b = scale;
			end
			MUL_HI: begin
				mul_a = div_quo[63:32];
				mul_b = scale;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (cmd.mul_op == MUL_LO) begin
			lo_q <= mul_p;
		end else if (cmd.mul_op != MUL_NONE) begin
			prod_q <= mul_p;
		end
		if (cmd.mul_op == MUL_D) begin
			neg_q <= di_neg_q ^ dneg_q[d_addr];
		end
	end

	// divider operands
	always_comb begin
		case (cmd.div_src)
			DIV_PROD: div_dvd = prod_q;
			DIV_SUM:  div_dvd = mag64(sum_sel);
			DIV_COV:  div_dvd = mag64(cov_rd);
			default:  div_dvd = prod_q;
		endcase
	end

	assign div_dvs = {1'b0, count_q} + (cmd.div_plus1 ? 33'd1 : 33'd0);

	acu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.quotient (div_quo),
		.done     (div_done)
	);

	// scale of the deviation product, rounded and capped at 2^63
	assign lo_r = {1'b0, lo_q} + 65'h8000;
	assign r65  = {1'b0, prod_q[47:0], 16'd0} + {16'd0, lo_r[64:16]};

	always_comb begin
		if (prod_q > HI_CAP) begin
			mq = MIN64;
		end else if (r65 > {1'b0, MIN64}) begin
			mq = MIN64;
		end else begin
			mq = r65[63:0];
		end
	end

	// covariance accumulation, the old value is discarded on the first update
	always_ff @(posedge clk) begin
		if (cmd.extra_load) begin
			extra_q <= div_quo;
		end
		if (cmd.scaled_load) begin
			scaled_q <= from_mag(neg_q, mq);
		end
		if (cmd.acc_sub_load) begin
			acc_q <= (count_q == 32'd1) ? 64'd0 :
				sat_sub(cov_rd, from_mag(cov_rd[63], div_quo));
		end else if (cmd.acc_add_load) begin
			acc_q <= sat_add(acc_q, scaled_q);
		end
	end

	assign new_cov  = sat_add(acc_q, diag ? extra_q : 64'd0);
	assign cov_addr = CAW'(int'(cmd.row) * DIM + int'(cmd.col));

	acu_ram #(
		.WIDTH (64),
		.DEPTH (CDEPTH)
	) u_cov_ram (
		.clk   (clk),
		.we    (cmd.out_load),
		.waddr (cov_addr),
		.wdata (new_cov),
		.raddr (cov_addr),
		.rdata (cov_rd)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_row_q  <= cmd.row;
			out_col_q  <= cmd.col;
			out_cov_q  <= new_cov;
			out_last_q <= diag && (cmd.row == IDX_W'(DIM - 1));
		end
	end

	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign out_cov   = out_cov_q;
	assign out_last  = out_last_q;

	assign status.div_done   = div_done;
	assign status.sample_end = sample_end;
	assign status.count_zero = count_q == '0;
	assign status.out_free   = !out_valid_q || m_tready;

`ifndef NO_ASSERTIONS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || m_tready))
		else $error("output register overwritten while full");
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("loaded item not presented");
	a_fire_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> (cmd.mul_op == MUL_NONE && !cmd.div_start && !cmd.update))
		else $error("item accepted during an update sweep");
	a_div_gap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !div_done)
		else $error("divider finished right after start");
`endif

endmodule

[rtl/acu_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acu_ctrl: sequencer of the covariance update sweep
// Walks the jitter term, the per-coordinate means and the lower triangle,
// issuing multiplier, divider and store commands to the datapath.
// ----------------------------------------------------------------------------
module acu_ctrl
	import acu_pkg::*;
#(
	parameter int DIM = DIMENSIONS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t status,
	output cmd_t    cmd,
	output logic    s_tready
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIM - 1);

	ctrl_state_t      state_q;
	ctrl_state_t      state_d;
	logic [IDX_W-1:0] row_q;
	logic [IDX_W-1:0] row_d;
	logic [IDX_W-1:0] col_q;
	logic [IDX_W-1:0] col_d;

	// state and entry counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			row_q   <= '0;
			col_q   <= '0;
		end else begin
			state_q <= state_d;
			row_q   <= row_d;
			col_q   <= col_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		row_d    = row_q;
		col_d    = col_q;
		s_tready = 1'b0;
		cmd      = '0;
		cmd.mul_op  = MUL_NONE;
		cmd.div_src = DIV_PROD;
		cmd.row     = row_q;
		cmd.col     = col_q;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (status.sample_end) begin
					state_d = status.count_zero ? S_UPDATE : S_EXTRA_MUL;
				end
			end
			S_EXTRA_MUL: begin
				cmd.mul_op = MUL_SE;
				state_d    = S_EXTRA_DIV;
			end
			S_EXTRA_DIV: begin
				cmd.div_start = 1'b1;
				cmd.div_src   = DIV_PROD;
				state_d       = S_EXTRA_WAIT;
			end
			S_EXTRA_WAIT: begin
				if (status.div_done) begin
					cmd.extra_load = 1'b1;
					row_d          = '0;
					state_d        = S_MEAN_DIV;
				end
			end
			S_MEAN_DIV: begin
				cmd.div_start = 1'b1;
				cmd.div_src   = DIV_SUM;
				state_d       = S_MEAN_WAIT;
			end
			S_MEAN_WAIT: begin
				cmd.div_src = DIV_SUM;
				if (status.div_done) begin
					cmd.d_we = 1'b1;
					if (row_q == LAST_IDX) begin
						row_d   = '0;
						col_d   = '0;
						state_d = S_LOAD_DI;
					end else begin
						row_d   = row_q + 1'b1;
						state_d = S_MEAN_DIV;
					end
				end
			end
			S_LOAD_DI: begin
				cmd.di_load = 1'b1;
				state_d     = S_PROD_MUL;
			end
			S_PROD_MUL: begin
				cmd.mul_op = MUL_D;
				state_d    = S_T_DIV;
			end
			S_T_DIV: begin
				cmd.div_start = 1'b1;
				cmd.div_src   = DIV_PROD;
				cmd.div_plus1 = 1'b1;
				state_d       = S_T_WAIT;
			end
			S_T_WAIT: begin
				if (status.div_done) begin
					state_d = S_LO_MUL;
				end
			end
			S_LO_MUL: begin
				cmd.mul_op = MUL_LO;
				state_d    = S_HI_MUL;
			end
			S_HI_MUL: begin
				cmd.mul_op = MUL_HI;
				state_d    = S_DEC_DIV;
			end
			S_DEC_DIV: begin
				cmd.div_start   = 1'b1;
				cmd.div_src     = DIV_COV;
				cmd.scaled_load = 1'b1;
				state_d         = S_DEC_WAIT;
			end
			S_DEC_WAIT: begin
				if (status.div_done) begin
					cmd.acc_sub_load = 1'b1;
					state_d          = S_ADD_SC;
				end
			end
			S_ADD_SC: begin
				cmd.acc_add_load = 1'b1;
				state_d          = S_COMBINE;
			end
			S_COMBINE: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					if (col_q == row_q) begin
						col_d = '0;
						if (row_q == LAST_IDX) begin
							row_d   = '0;
							state_d = S_UPDATE;
						end else begin
							row_d   = row_q + 1'b1;
							state_d = S_LOAD_DI;
						end
					end else begin
						col_d   = col_q + 1'b1;
						state_d = S_LOAD_DI;
					end
				end
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[rtl/adaptive_covariance_update_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_covariance_update_unit: recursive chain covariance estimator
// Sample coordinates come in on the slave stream, one item each, s_tlast on
// the final coordinate (a sample also ends after DIMENSIONS coordinates).
// The first sample seeds the running sum. Each later sample updates the
// lower triangle of the Q32.32 covariance and sends it out row by row on the
// master stream, m_tlast on the last diagonal entry.
// Coordinates that do not end a sample are accepted without stalling.
// The end of each later sample starts a sweep through one shared divider:
// one division for the jitter term and one for each coordinate mean, then
// two divisions per triangle entry. No item is accepted during the sweep.
// A stalled receiver holds the sweep at the next entry; the final entry may
// wait in the output register while new coordinates are accepted.
// Reset clears sums, count and position; the covariance memory needs no
// clearing since the first update discards its old contents.
// Configuration: scale_factor at 0x0, jitter at 0x4, write only when idle.
// ----------------------------------------------------------------------------
module adaptive_covariance_update_unit
	import acu_pkg::*;
#(
	parameter int DIMENSIONS = DIMENSIONS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// slave stream: [31:0] element_value
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [31:0]       s_tdata,
	input  logic              s_tlast,
	// master stream: [2:0] row_index, [5:3] col_index, [69:6] cov_value
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [71:0]       m_tdata,
	output logic              m_tlast,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [31:0]      scale_q;
	logic [15:0]      jitter_q;
	logic             cfg_we;
	logic             in_fire;
	cmd_t             cmd;
	status_t          status;
	logic [IDX_W-1:0] out_row;
	logic [IDX_W-1:0] out_col;
	logic [63:0]      out_cov;

	// register file
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= SCALE_RESET;
			jitter_q <= JITTER_RESET;
		end else if (cfg_we) begin
			case (paddr[2])
				REG_SCALE:  scale_q  <= pwdata;
				REG_JITTER: jitter_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_SCALE:  prdata = scale_q;
			REG_JITTER: prdata = {16'd0, jitter_q};
			default:    prdata = '0;
		endcase
	end

	assign in_fire = s_tvalid && s_tready;

	acu_ctrl #(
		.DIM (DIMENSIONS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.status   (status),
		.cmd      (cmd),
		.s_tready (s_tready)
	);

	acu_datapath #(
		.DIM (DIMENSIONS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.scale     (scale_q),
		.jitter    (jitter_q),
		.in_fire   (in_fire),
		.in_value  (s_tdata),
		.in_last   (s_tlast),
		.m_tready  (m_tready),
		.out_valid (m_tvalid),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_cov   (out_cov),
		.out_last  (m_tlast)
	);

	assign m_tdata = {2'b00, out_cov, out_col, out_row};

endmodule
